### rtl/core/csu_pkg.sv
`default_nettype none

package csu_pkg;

    localparam int NUM_SEMS  = 4;
    localparam int NUM_PROCS = 16;

    localparam int SEM_W   = 2;
    localparam int PROC_W  = 4;
    localparam int CFG_W   = 4;
    localparam int COUNT_W = 6;
    localparam int SLOT_W  = $clog2(NUM_PROCS);
    localparam int LEN_W   = SLOT_W + 1;
    localparam int ADDR_W  = SEM_W + SLOT_W;
    localparam int QDEPTH  = 2 ** ADDR_W;

    localparam logic signed [COUNT_W-1:0] COUNT_MAX   = 6'sd31;
    localparam logic signed [COUNT_W-1:0] COUNT_MIN   = -6'sd16;
    localparam logic signed [COUNT_W-1:0] COUNT_RESET = 6'sd1;

    typedef enum logic [0:0] {
        KIND_WAIT   = 1'b0,
        KIND_SIGNAL = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_PROCEED = 2'd0,
        ST_BLOCKED = 2'd1,
        ST_ERROR   = 2'd2
    } status_t;

endpackage

`default_nettype wire

### rtl/core/csu_ram.sv
`default_nettype none

module csu_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/counting_semaphore_unit.sv
`default_nettype none

// Bank of NUM_SEMS counting semaphores, each with a FIFO of waiting process
// numbers held in one shared queue RAM (one row of NUM_PROCS slots per
// semaphore). Every input beat gives exactly one result beat: wait lowers the
// count and queues the caller once the count goes negative; signal raises it
// and pops the oldest waiter while the count stays at or below zero. Each
// operation is one read-modify-write of the count, head and length registers
// plus at most one queue RAM access, so the block takes one beat per cycle while the result
// is not stalled and shows it in the cycle after acceptance; the woken process number comes
// straight from the RAM's registered read port. Config writes reload a
// semaphore's count and empty its queue; issue them only while the block is
// idle. There is no clearing pass: queue slots are only read after written.

module counting_semaphore_unit
    import csu_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,

    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [SEM_W-1:0]          cfg_index,
    input  wire logic [CFG_W-1:0]          cfg_data,

    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic                      s_kind,
    input  wire logic [SEM_W-1:0]          s_sem_index,
    input  wire logic [PROC_W-1:0]         s_proc_id,

    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [1:0]                     m_status,
    output logic                           m_woke_valid,
    output logic [PROC_W-1:0]              m_woke_proc,
    output logic signed [COUNT_W-1:0]      m_count_after
);

    logic signed [COUNT_W-1:0] sem_count_reg  [NUM_SEMS];
    logic signed [COUNT_W-1:0] sem_count_next [NUM_SEMS];
    logic [SLOT_W-1:0]         head_reg       [NUM_SEMS];
    logic [SLOT_W-1:0]         head_next      [NUM_SEMS];
    logic [LEN_W-1:0]          len_reg        [NUM_SEMS];
    logic [LEN_W-1:0]          len_next       [NUM_SEMS];

    logic                      m_valid_reg;
    status_t                   status_reg;
    logic                      woke_valid_reg;
    logic signed [COUNT_W-1:0] count_out_reg;

    status_t                   res_status;
    logic                      res_woke;
    logic signed [COUNT_W-1:0] res_count;

    logic                      s_fire;
    logic                      in_range;
    logic signed [COUNT_W-1:0] cur_cnt;
    logic [SLOT_W-1:0]         cur_head;
    logic [LEN_W-1:0]          cur_len;
    logic [LEN_W-1:0]          tail_sum;
    logic [SLOT_W-1:0]         tail;
    logic [SLOT_W-1:0]         head_inc;

    logic                      q_we;
    logic                      q_re;
    logic [ADDR_W-1:0]         q_waddr;
    logic [ADDR_W-1:0]         q_raddr;
    logic [PROC_W-1:0]         q_rdata;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;

    assign in_range = 32'(s_sem_index) < NUM_SEMS;
    assign cur_cnt  = sem_count_reg[s_sem_index];
    assign cur_head = head_reg[s_sem_index];
    assign cur_len  = len_reg[s_sem_index];

    // ring position of the tail and the slot after the head
    assign tail_sum = {1'b0, cur_head} + cur_len;
    assign tail     = (tail_sum >= LEN_W'(NUM_PROCS)) ?
                      SLOT_W'(tail_sum - LEN_W'(NUM_PROCS)) : tail_sum[SLOT_W-1:0];
    assign head_inc = (cur_head == SLOT_W'(NUM_PROCS - 1)) ? '0 : cur_head + 1'b1;

    assign q_waddr = {s_sem_index, tail};
    assign q_raddr = {s_sem_index, cur_head};

    always_comb begin
        sem_count_next = sem_count_reg;
        head_next      = head_reg;
        len_next       = len_reg;
        res_status     = ST_PROCEED;
        res_woke       = 1'b0;
        res_count      = cur_cnt;
        q_we           = 1'b0;
        q_re           = 1'b0;

        if (s_fire) begin
            if (!in_range) begin
                res_status = ST_ERROR;
                res_count  = '0;
            end else begin
                unique case (kind_t'(s_kind))
                    KIND_WAIT: begin
                        if (cur_cnt > 0) begin
                            res_count = cur_cnt - 2'sd1;
                        end else if (cur_len >= LEN_W'(NUM_PROCS) || cur_cnt <= COUNT_MIN) begin
                            res_status = ST_ERROR;
                        end else begin
                            q_we       = 1'b1;
                            res_status = ST_BLOCKED;
                            res_count  = cur_cnt - 2'sd1;
                            len_next[s_sem_index] = cur_len + 1'b1;
                        end
                    end
                    KIND_SIGNAL: begin
                        if (cur_cnt >= COUNT_MAX) begin
                            res_status = ST_ERROR;
                        end else begin
                            res_count = cur_cnt + 2'sd1;
                            // pop the oldest waiter while the count stays non-positive
                            if (res_count <= 0 && cur_len != '0) begin
                                q_re     = 1'b1;
                                res_woke = 1'b1;
                                head_next[s_sem_index] = head_inc;
                                len_next[s_sem_index]  = cur_len - 1'b1;
                            end
                        end
                    end
                endcase
                sem_count_next[s_sem_index] = res_count;
            end
        end

        if (cfg_valid && 32'(cfg_index) < NUM_SEMS) begin
            sem_count_next[cfg_index] = COUNT_W'({1'b0, cfg_data});
            head_next[cfg_index]      = '0;
            len_next[cfg_index]       = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_SEMS; i++) begin
                sem_count_reg[i] <= COUNT_RESET;
                head_reg[i]      <= '0;
                len_reg[i]       <= '0;
            end
        end else begin
            sem_count_reg <= sem_count_next;
            head_reg      <= head_next;
            len_reg       <= len_next;
            if (s_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload: load on every accepted beat, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            status_reg     <= res_status;
            woke_valid_reg <= res_woke;
            count_out_reg  <= res_count;
        end
    end

    csu_ram #(
        .WIDTH (PROC_W),
        .DEPTH (QDEPTH)
    ) u_queue (
        .aclk  (aclk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (s_proc_id),
        .re    (q_re),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_woke_valid  = woke_valid_reg;
    assign m_woke_proc   = woke_valid_reg ? q_rdata : '0;
    assign m_count_after = count_out_reg;

endmodule

`default_nettype wire

### rtl/core/csu_checker.sv
`default_nettype none

module csu_checker
    import csu_pkg::*;
(
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      m_valid,
    input wire logic                      m_ready,
    input wire logic [1:0]                m_status,
    input wire logic                      m_woke_valid,
    input wire logic [PROC_W-1:0]         m_woke_proc,
    input wire logic signed [COUNT_W-1:0] m_count_after
);

    // no result beat comes straight out of reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat valid right after reset");

    // a wake only comes from a successful signal that leaves the count non-positive
    a_wake_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_woke_valid |-> m_status == ST_PROCEED && m_count_after <= 0)
        else $error("wake reported with bad status or positive count");

    // a blocked caller always leaves the count negative
    a_block_neg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_BLOCKED |-> m_count_after < 0)
        else $error("blocked beat with non-negative count");

    a_no_wake_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_woke_valid |-> m_woke_proc == '0)
        else $error("woken process number without a wake");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_woke_proc)
            && $stable(m_count_after))
        else $error("stalled result beat changed");

endmodule

bind counting_semaphore_unit csu_checker u_csu_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_woke_valid  (m_woke_valid),
    .m_woke_proc   (m_woke_proc),
    .m_count_after (m_count_after)
);

`default_nettype wire

### verif/tb_counting_semaphore_unit.sv
module tb_counting_semaphore_unit;
    import csu_pkg::*;

    typedef struct {
        status_t                   status;
        logic                      woke_valid;
        logic [PROC_W-1:0]         woke_proc;
        logic signed [COUNT_W-1:0] count_after;
    } sem_result_t;

    typedef logic [CFG_W-1:0] init_set_t [NUM_SEMS];

    // Mirror of the semaphore bank: counts, init registers and wait rings.
    class semaphore_mirror;
        logic [CFG_W-1:0]          init_count [NUM_SEMS];
        logic signed [COUNT_W-1:0] count [NUM_SEMS];
        logic [PROC_W-1:0]         waiters [NUM_SEMS][NUM_PROCS];
        int                        head [NUM_SEMS];
        int                        depth [NUM_SEMS];
        sem_result_t               pending_results [$];
        int                        mismatches;

        function new();
            mismatches = 0;
            for (int s = 0; s < NUM_SEMS; s++) begin
                init_count[s] = CFG_W'(1);
                count[s] = COUNT_RESET;
                head[s] = 0;
                depth[s] = 0;
            end
        endfunction

        function void load_init(int idx, logic [CFG_W-1:0] val);
            if (idx >= NUM_SEMS) return;
            init_count[idx] = val;
            count[idx] = COUNT_W'({2'b00, val});
            head[idx] = 0;
            depth[idx] = 0;
        endfunction

        function void note_op(kind_t kind, logic [SEM_W-1:0] sem, logic [PROC_W-1:0] pid);
            sem_result_t r;
            int c;
            int tail;
            r.status = ST_PROCEED;
            r.woke_valid = 1'b0;
            r.woke_proc = '0;
            r.count_after = '0;
            if (int'(sem) >= NUM_SEMS) begin
                r.status = ST_ERROR;
                pending_results = {pending_results, r};
                return;
            end
            c = int'(count[sem]);
            if (kind == KIND_WAIT) begin
                if (c > 0) begin
                    count[sem] = COUNT_W'(c - 1);
                end else if (depth[sem] >= NUM_PROCS || c <= int'(COUNT_MIN)) begin
                    r.status = ST_ERROR;
                end else begin
                    tail = (head[sem] + depth[sem]) % NUM_PROCS;
                    waiters[sem][tail] = pid;
                    depth[sem]++;
                    count[sem] = COUNT_W'(c - 1);
                    r.status = ST_BLOCKED;
                end
            end else if (c >= int'(COUNT_MAX)) begin
                r.status = ST_ERROR;
            end else begin
                count[sem] = COUNT_W'(c + 1);
                // pop the oldest waiter while the count stays non-positive
                if (c + 1 <= 0 && depth[sem] > 0) begin
                    r.woke_valid = 1'b1;
                    r.woke_proc = waiters[sem][head[sem]];
                    head[sem] = (head[sem] + 1) % NUM_PROCS;
                    depth[sem]--;
                end
            end
            r.count_after = count[sem];
            pending_results = {pending_results, r};
        endfunction

        function void check_result(logic [1:0] status, logic woke_valid,
                                   logic [PROC_W-1:0] woke_proc,
                                   logic signed [COUNT_W-1:0] count_after);
            sem_result_t exp;
            if (pending_results.size() == 0) begin
                $error("result beat with no operation outstanding");
                mismatches++;
                return;
            end
            exp = pending_results.pop_front();
            if (status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, status);
                mismatches++;
            end
            if (woke_valid !== exp.woke_valid) begin
                $error("woke_valid: expected %0d, got %0d", exp.woke_valid, woke_valid);
                mismatches++;
            end
            if (woke_proc !== exp.woke_proc) begin
                $error("woke_proc: expected %0d, got %0d", exp.woke_proc, woke_proc);
                mismatches++;
            end
            if (count_after !== exp.count_after) begin
                $error("count_after: expected %0d, got %0d", exp.count_after, count_after);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [SEM_W-1:0]          cfg_index;
    logic [CFG_W-1:0]          cfg_data;
    logic                      s_valid;
    logic                      s_ready;
    logic                      s_kind;
    logic [SEM_W-1:0]          s_sem_index;
    logic [PROC_W-1:0]         s_proc_id;
    logic                      m_valid;
    logic                      m_ready;
    logic [1:0]                m_status;
    logic                      m_woke_valid;
    logic [PROC_W-1:0]         m_woke_proc;
    logic signed [COUNT_W-1:0] m_count_after;

    semaphore_mirror sems = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    counting_semaphore_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_sem_index   (s_sem_index),
        .s_proc_id     (s_proc_id),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_woke_valid  (m_woke_valid),
        .m_woke_proc   (m_woke_proc),
        .m_count_after (m_count_after)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // result side: check each accepted beat, then pick next cycle's ready
    initial begin : result_sink
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sems.check_result(m_status, m_woke_valid, m_woke_proc, m_count_after);
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_op(kind_t kind, logic [SEM_W-1:0] sem, logic [PROC_W-1:0] pid);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_sem_index <= sem;
        s_proc_id <= pid;
        do @(posedge aclk); while (!s_ready);
        sems.note_op(kind, sem, pid);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (sems.outstanding() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic load_all_inits(init_set_t vals);
        for (int i = 0; i < NUM_SEMS; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= SEM_W'(i);
            cfg_data <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            sems.load_init(i, vals[i]);
        end
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // runs of operations focused on one semaphore, leaning to wait or signal,
    // so queues fill up and counts climb to the top
    task automatic run_traffic(int n_ops);
        int sent;
        int run_len;
        int wait_pct;
        logic [SEM_W-1:0] focus;
        logic [SEM_W-1:0] sem;
        kind_t kind;
        sent = 0;
        while (sent < n_ops) begin
            focus = SEM_W'($urandom_range(NUM_SEMS - 1));
            run_len = $urandom_range(36, 8);
            case ($urandom_range(2))
                0: wait_pct = 5;
                1: wait_pct = 50;
                default: wait_pct = 95;
            endcase
            for (int i = 0; i < run_len && sent < n_ops; i++) begin
                kind = ($urandom_range(99) < wait_pct) ? KIND_WAIT : KIND_SIGNAL;
                sem = ($urandom_range(99) < 85) ? focus : SEM_W'($urandom);
                send_op(kind, sem, PROC_W'($urandom));
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        init_set_t inits;
        aresetn <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_kind <= KIND_WAIT;
        s_sem_index <= '0;
        s_proc_id <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        inits = '{CFG_W'(15), CFG_W'(0), CFG_W'(1), CFG_W'(1)};
        load_all_inits(inits);
        // block two callers, wake them in order, then climb past zero
        send_op(KIND_WAIT, 2'd1, 4'd0);
        send_op(KIND_WAIT, 2'd1, 4'd15);
        send_op(KIND_SIGNAL, 2'd1, 4'd3);
        send_op(KIND_SIGNAL, 2'd1, 4'd7);
        send_op(KIND_SIGNAL, 2'd1, 4'd8);
        send_op(KIND_WAIT, 2'd1, 4'd9);
        send_op(KIND_WAIT, 2'd2, 4'd5);
        send_op(KIND_SIGNAL, 2'd3, 4'd10);
        // saturate the count at its top; the last signal is refused
        for (int i = 0; i < 17; i++)
            send_op(KIND_SIGNAL, 2'd0, PROC_W'($urandom));
        drain_results();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: inits = '{CFG_W'(0), CFG_W'(0), CFG_W'(0), CFG_W'(0)};
                1: inits = '{CFG_W'(15), CFG_W'(15), CFG_W'(15), CFG_W'(15)};
                2: inits = '{CFG_W'(0), CFG_W'(15), CFG_W'(1), CFG_W'(7)};
                default: begin
                    for (int s = 0; s < NUM_SEMS; s++)
                        inits[s] = CFG_W'($urandom_range(15));
                end
            endcase
            send_idle_pct = 0;
            recv_stall_pct = 0;
            load_all_inits(inits);
            case (p % 4)
                1: send_idle_pct = 71;
                2: recv_stall_pct = 71;
                3: begin
                    send_idle_pct = 16;
                    recv_stall_pct = 16;
                end
                default: ;
            endcase
            run_traffic(135);
            drain_results();
        end

        repeat (4) @(posedge aclk);
        if (sems.mismatches == 0 && sems.outstanding() == 0)
            $display("** counting_semaphore_unit: PASSED **");
        else
            $display("** counting_semaphore_unit: FAILED **");
        $finish;
    end

    initial begin : watchdog
        #1200000;
        $display("** counting_semaphore_unit: FAILED **");
        $finish;
    end

endmodule
